/* hw/rtl/qat_pkg.sv */
// shared types and constants for the quoted argument tokenizer
// result item layout, result kinds, quote modes and character codes
// no dependencies
package qat_pkg;

  localparam int unsigned MaxResults = 3;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_TOKEN_END = 2'd1,
    KIND_LINE_END  = 2'd2
  } kind_t;

  typedef logic [1:0] quote_mode_t;

  localparam quote_mode_t QM_NONE   = 2'd0;
  localparam quote_mode_t QM_SINGLE = 2'd1;
  localparam quote_mode_t QM_DOUBLE = 2'd2;

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_APOS   = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       err;
  } result_t;

  typedef struct packed {
    logic [1:0]                    cnt;
    result_t [MaxResults-1:0]      res;
  } result_set_t;

endpackage

/* hw/rtl/qat_decode.sv */
// tokenizer state and per-byte decode into a set of up to three results
// depends on qat_pkg
module qat_decode (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 advance,
  input  logic [7:0]           in_byte,
  output qat_pkg::result_set_t set
);
  import qat_pkg::*;

  quote_mode_t quote_mode, quote_mode_next;
  logic        backslash_pending, backslash_pending_next;
  logic        inside_token, inside_token_next;

  logic [1:0]  n;
  logic        done;
  logic        sep;
  result_t [MaxResults-1:0] res;

  always_comb begin
    n = 2'd0;
    done = 1'b0;
    res = '0;
    quote_mode_next = quote_mode;
    backslash_pending_next = backslash_pending;
    inside_token_next = inside_token;
    sep = (in_byte == CH_SPACE) || (in_byte >= CH_TAB && in_byte <= CH_CR);

    if (backslash_pending) begin
      backslash_pending_next = 1'b0;
      res[n].kind = KIND_DATA;
      if (in_byte == CH_APOS) begin
        res[n].data = CH_APOS;
        done = 1'b1;
      end else begin
        res[n].data = CH_BSLASH;
      end
      n = n + 2'd1;
    end

    if (!done) begin
      if (in_byte == CH_NUL) begin
        if (inside_token) begin
          res[n].kind = KIND_TOKEN_END;
          n = n + 2'd1;
        end
        res[n].kind = KIND_LINE_END;
        res[n].err = (quote_mode != QM_NONE);
        n = n + 2'd1;
        quote_mode_next = QM_NONE;
        inside_token_next = 1'b0;
      end else if (quote_mode == QM_NONE) begin
        if (sep) begin
          if (inside_token) begin
            res[n].kind = KIND_TOKEN_END;
            n = n + 2'd1;
            inside_token_next = 1'b0;
          end
        end else begin
          inside_token_next = 1'b1;
          if (in_byte == CH_APOS) begin
            quote_mode_next = QM_SINGLE;
          end else if (in_byte == CH_DQUOTE) begin
            quote_mode_next = QM_DOUBLE;
          end else begin
            res[n].kind = KIND_DATA;
            res[n].data = in_byte;
            n = n + 2'd1;
          end
        end
      end else begin
        inside_token_next = 1'b1;
        if (quote_mode == QM_SINGLE && in_byte == CH_BSLASH) begin
          backslash_pending_next = 1'b1;
        end else if ((quote_mode == QM_SINGLE && in_byte == CH_APOS) ||
                     (quote_mode == QM_DOUBLE && in_byte == CH_DQUOTE)) begin
          quote_mode_next = QM_NONE;
        end else begin
          res[n].kind = KIND_DATA;
          res[n].data = in_byte;
          n = n + 2'd1;
        end
      end
    end

    set.cnt = n;
    set.res = res;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quote_mode <= QM_NONE;
      backslash_pending <= 1'b0;
      inside_token <= 1'b0;
    end else if (advance) begin
      quote_mode <= quote_mode_next;
      backslash_pending <= backslash_pending_next;
      inside_token <= inside_token_next;
    end
  end

endmodule

/* hw/rtl/qat_result_buf.sv */
// result register that hands out one result per cycle from a loaded set while out_ready is high
// depends on qat_pkg
module qat_result_buf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  qat_pkg::result_set_t set,
  output logic                 free,
  output logic                 out_valid,
  input  logic                 out_ready,
  output qat_pkg::result_t     head,
  output logic                 head_last
);
  import qat_pkg::*;

  result_t [MaxResults-1:0] slots;
  logic [1:0]               left;
  logic                     pop;

  assign out_valid = (left != 2'd0);
  assign pop       = out_valid && out_ready;
  assign free      = (left == 2'd0) || (left == 2'd1 && out_ready);
  assign head      = slots[0];
  assign head_last = (left == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      left <= 2'd0;
    end else if (load) begin
      left <= set.cnt;
    end else if (pop) begin
      left <= left - 2'd1;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (load) begin
      slots <= set.res;
    end else if (pop) begin
      slots <= {result_t'('0), slots[MaxResults-1:1]};
    end
  end

endmodule

/* hw/rtl/quoted_argument_tokenizer.sv */
// Shell-style argument tokenizer: takes one line byte per item (0 ends the line) and
// gives data bytes, token ends and a line end with an open-quote flag. One byte is
// taken every cycle while each byte yields at most one result and out_ready is high;
// a byte yielding two or three results holds the input until the single result port
// has passed them on. A byte passes an input register, then decode into the result
// register, where its first result shows. Depends on qat_pkg and submodules.
module quoted_argument_tokenizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] result_kind,
  output logic [7:0] out_byte,
  output logic       open_quote_error,
  output logic       last
);
  import qat_pkg::*;

  logic        held;
  logic [7:0]  held_byte;
  logic        free;
  logic        advance;
  result_set_t set;
  result_t     head;
  logic        head_last;

  assign advance  = held && free;
  assign in_ready = !held || free;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_byte <= in_byte;
    end
  end

  qat_decode u_decode (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .in_byte (held_byte),
    .set     (set)
  );

  qat_result_buf u_result_buf (
    .clk       (clk),
    .rst       (rst),
    .load      (advance),
    .set       (set),
    .free      (free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .head      (head),
    .head_last (head_last)
  );

  assign result_kind      = head.kind;
  assign out_byte         = head.data;
  assign open_quote_error = head.err;
  assign last             = head_last;

endmodule
